>>> design/skp_pkg.sv
// Package: shared types and constants for the shuffle and k-fold partition block
`timescale 1ns / 1ps
package skp_pkg;

    localparam logic [47:0] LCG_MUL = 48'h0005_DEEC_E66D;
    localparam logic [47:0] LCG_ADD = 48'h0000_0000_000B;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_FOLDS = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_RNG,
        ST_SWAP_RD,
        ST_SWAP_WR,
        ST_DIV,
        ST_GRP,
        ST_SORT,
        ST_EMIT
    } skp_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // latch seed and config, reset counters
        logic fill;       // write one identity entry
        logic rng_step;   // advance generator (multi-cycle)
        logic swap_rd;    // read entries i and j
        logic swap_wr;    // write swapped entries, decrement i
        logic div_step;   // one step of n / fc
        logic grp_init;   // start a new group
        logic sort_step;  // one selection step
        logic emit;       // present one value to the output register
    } skp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic fill_done;
        logic swap_none;  // single item: no swap needed
        logic rng_done;
        logic swap_done;
        logic div_done;
        logic sort_done;
        logic grp_done;
        logic run_done;
        logic out_busy;
    } skp_stat_t;

endpackage

>>> design/skp_ctrl.sv
// Controller: sequencing state machine for the shuffle and partition run
`timescale 1ns / 1ps
module skp_ctrl
    import skp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  skp_stat_t stat,
    output skp_cmd_t  cmd,
    output logic      idle
);

    skp_state_t state_reg;
    skp_state_t state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (start) state_next = ST_FILL;
            ST_FILL:    if (stat.fill_done) state_next = stat.swap_none ? ST_DIV : ST_RNG;
            ST_RNG:     if (stat.rng_done) state_next = ST_SWAP_RD;
            ST_SWAP_RD: state_next = ST_SWAP_WR;
            ST_SWAP_WR: state_next = stat.swap_done ? ST_DIV : ST_RNG;
            ST_DIV:     if (stat.div_done) state_next = ST_GRP;
            ST_GRP:     state_next = ST_SORT;
            ST_SORT:    if (stat.sort_done) state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    if (stat.run_done)
                        state_next = ST_IDLE;
                    else if (stat.grp_done)
                        state_next = ST_GRP;
                    else
                        state_next = ST_SORT;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd = '0;
        idle = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                cmd.load = start;
            end
            ST_FILL:    cmd.fill = 1'b1;
            ST_RNG:     cmd.rng_step = 1'b1;
            ST_SWAP_RD: cmd.swap_rd = 1'b1;
            ST_SWAP_WR: cmd.swap_wr = 1'b1;
            ST_DIV:     cmd.div_step = 1'b1;
            ST_GRP:     cmd.grp_init = 1'b1;
            ST_SORT:    cmd.sort_step = 1'b1;
            ST_EMIT:    cmd.emit = !stat.out_busy;
            default:    cmd = '0;
        endcase
    end

endmodule

>>> design/skp_dp.sv
// Datapath: generator, permutation memory, divider, group sorter and output register
`timescale 1ns / 1ps
module skp_dp
    import skp_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)(
    input  logic               clk,
    input  logic               rst_n,
    input  skp_cmd_t           cmd,
    output skp_stat_t          stat,
    input  logic [47:0]        seed,
    input  logic [31:0]        base_cfg,
    input  logic [6:0]         count_cfg,
    input  logic [6:0]         folds_cfg,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] value,
    output logic [6:0]         group_index,
    output logic               group_end,
    output logic               run_end
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [6:0] MAX_N = 7'(MAX_ITEMS);

    // Permutation memory
    logic [5:0] mem [MAX_ITEMS];

    logic [CW-1:0] n_reg;
    logic [6:0]    fc_reg;
    logic [31:0]   base_reg;
    logic [47:0]   rng_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] k_reg;
    logic [1:0]    mph_reg;
    logic [47:0]   acc_reg;
    logic [5:0]    rdi_reg;
    logic [5:0]    rdj_reg;
    logic [AW-1:0] j_reg;
    // Divider
    logic [6:0]    quo_reg;
    logic [6:0]    rem_reg;
    logic [2:0]    dcnt_reg;
    // Group
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] len_reg;
    logic [6:0]    grp_reg;
    logic [MAX_ITEMS-1:0] used_reg;
    logic [CW-1:0] scan_reg;
    logic [5:0]    cand_reg;
    logic [AW-1:0] candi_reg;
    logic          candl_reg;
    logic          candv_reg;
    logic [CW-1:0] emitted_reg;
    logic [5:0]    best_reg;
    logic [AW-1:0] besti_reg;
    logic          bestv_reg;
    logic          ready_reg;

    logic [6:0]    count_sat;
    logic [6:0]    folds_sat;
    logic [63:0]   prod16;
    logic [47:0]   lcg_full;
    logic [54:0]   jprod;
    logic [AW-1:0] j_idx;
    logic [6:0]    n7;
    logic [7:0]    dtrial;
    logic [CW-1:0] rem_len;
    logic [CW-1:0] cap_len;
    logic [31:0]   cand_val;
    logic [31:0]   best_val;

    assign count_sat = (count_cfg == 7'd0) ? 7'd1 : ((count_cfg > MAX_N) ? MAX_N : count_cfg);
    assign folds_sat = (folds_cfg == 7'd0) ? 7'd1 : folds_cfg;

    // Generator: X*MUL in three 16-bit slices of X, one slice per rng_step
    assign prod16   = {48'd0, rng_reg[16*mph_reg +: 16]} * {16'd0, LCG_MUL};
    assign lcg_full = acc_reg + (prod16[47:0] << (16 * mph_reg));

    // j-1 = (i*X)>>48, i <= 64: top bits of X times i
    assign jprod = {7'd0, rng_reg} * {48'd0, 7'(i_reg)};
    assign j_idx = AW'(jprod[54:48]);

    // Restoring division: bring down the next bit of n
    assign n7     = 7'(n_reg);
    assign dtrial = {rem_reg, n7[3'd6 - dcnt_reg]};

    assign rem_len = n_reg - pos_reg;
    assign cap_len = (quo_reg >= MAX_N) ? CW'(MAX_N) : CW'(quo_reg + 7'd1);

    assign cand_val = base_reg + 32'(cand_reg);
    assign best_val = base_reg + 32'(best_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rng_reg  <= seed;
            n_reg    <= CW'(count_sat);
            fc_reg   <= folds_sat;
            base_reg <= base_cfg;
            i_reg    <= CW'(count_sat);
            k_reg    <= '0;
            mph_reg  <= '0;
            acc_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dcnt_reg <= '0;
            pos_reg  <= '0;
            grp_reg  <= '0;
            emitted_reg <= '0;
        end
        if (cmd.fill)
        begin
            mem[k_reg[AW-1:0]] <= 6'(k_reg);
            k_reg <= k_reg + 1'b1;
        end
        if (cmd.rng_step)
        begin
            if (mph_reg == 2'd2)
            begin
                rng_reg <= lcg_full + LCG_ADD;
                mph_reg <= '0;
                acc_reg <= '0;
            end
            else
            begin
                acc_reg <= lcg_full;
                mph_reg <= mph_reg + 1'b1;
            end
        end
        if (cmd.swap_rd)
        begin
            j_reg   <= j_idx;
            rdi_reg <= mem[AW'(i_reg - 1'b1)];
            rdj_reg <= mem[j_idx];
        end
        if (cmd.swap_wr)
        begin
            mem[AW'(i_reg - 1'b1)] <= rdj_reg;
            mem[j_reg]             <= rdi_reg;
            i_reg <= i_reg - 1'b1;
        end
        // Restoring division n / fc, one quotient bit per cycle
        if (cmd.div_step)
        begin
            if (dtrial >= {1'b0, fc_reg})
            begin
                rem_reg <= 7'(dtrial - {1'b0, fc_reg});
                quo_reg <= {quo_reg[5:0], 1'b1};
            end
            else
            begin
                rem_reg <= dtrial[6:0];
                quo_reg <= {quo_reg[5:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        // Start a new group
        if (cmd.grp_init)
        begin
            len_reg   <= (grp_reg < fc_reg && rem_len > cap_len) ? cap_len : rem_len;
            used_reg  <= '0;
            scan_reg  <= '0;
            candv_reg <= 1'b0;
            bestv_reg <= 1'b0;
            ready_reg <= 1'b0;
            k_reg     <= '0;
        end
        if (cmd.sort_step)
        begin
            // Issue one registered memory read per cycle across the group
            if (scan_reg != len_reg)
            begin
                cand_reg  <= mem[AW'(pos_reg + scan_reg)];
                candi_reg <= AW'(scan_reg);
                candl_reg <= (scan_reg + 1'b1 == len_reg);
                candv_reg <= 1'b1;
                scan_reg  <= scan_reg + 1'b1;
            end
            else
            begin
                candv_reg <= 1'b0;
            end
            // Keep the smallest unused value, compared as wrapped signed
            if (candv_reg)
            begin
                if (!used_reg[candi_reg] &&
                    (!bestv_reg || ($signed(cand_val) < $signed(best_val))))
                begin
                    best_reg  <= cand_reg;
                    besti_reg <= candi_reg;
                    bestv_reg <= 1'b1;
                end
                if (candl_reg)
                    ready_reg <= 1'b1;
            end
        end
        if (cmd.emit)
        begin
            used_reg[besti_reg] <= 1'b1;
            k_reg       <= k_reg + 1'b1;
            emitted_reg <= emitted_reg + 1'b1;
            scan_reg    <= '0;
            candv_reg   <= 1'b0;
            bestv_reg   <= 1'b0;
            ready_reg   <= 1'b0;
            if (k_reg + 1'b1 == len_reg)
            begin
                pos_reg <= pos_reg + len_reg;
                if (grp_reg < fc_reg)
                    grp_reg <= grp_reg + 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            value       <= best_val;
            group_index <= grp_reg;
            group_end   <= (k_reg + 1'b1 == len_reg);
            run_end     <= (emitted_reg + 1'b1 == n_reg);
        end
    end

    // Status
    always_comb
    begin
        stat = '0;
        stat.fill_done = (k_reg + 1'b1 == n_reg);
        stat.swap_none = (n_reg == CW'(1));
        stat.rng_done  = (mph_reg == 2'd2);
        stat.swap_done = (i_reg <= CW'(2));
        stat.div_done  = (dcnt_reg == 3'd6);
        stat.sort_done = ready_reg;
        stat.grp_done  = (k_reg + 1'b1 == len_reg);
        stat.run_done  = (emitted_reg + 1'b1 == n_reg);
        stat.out_busy  = out_valid && out_stall;
    end

endmodule

>>> design/shuffle_kfold_partition.sv
// Top level: shuffle and k-fold partition block with configuration registers
`timescale 1ns / 1ps
// Usage:
//   Write range_base, item_count and fold_count over the configuration port
//   (index 0, 1, 2; other indexes are ignored) while the block is idle.
//   Transfer one seed on the input channel to start a run. The block fills
//   its permutation memory, performs n-1 Fisher-Yates swaps, each taking
//   one pass of the shared 16x48 generator multiplier per 16-bit slice of
//   the state plus a read and a write, and divides n by fold_count by
//   restoring division. Each group then takes one setup step, and each value
//   a selection scan over registered memory reads and one emit step. Input
//   stall stays high until the last value of the run is in the output
//   register and drops in that same cycle. Output values sit in an output
//   register; while the receiver stalls a held value the sequencer waits.
//   Reset returns the registers to base 0, count 64, folds 4, with no run
//   active.
module shuffle_kfold_partition
    import skp_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [47:0]        seed,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] value,
    output logic [6:0]         group_index,
    output logic               group_end,
    output logic               run_end
);

    logic [31:0] base_reg;
    logic [6:0]  count_reg;
    logic [6:0]  folds_reg;
    skp_cmd_t    cmd;
    skp_stat_t   stat;
    logic        idle;

    assign cfg_ready = 1'b1;
    assign in_stall  = !idle;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            count_reg <= 7'd64;
            folds_reg <= 7'd4;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BASE:  base_reg  <= cfg_data;
                REG_COUNT: count_reg <= cfg_data[6:0];
                REG_FOLDS: folds_reg <= cfg_data[6:0];
                default:   ;
            endcase
        end
    end

    skp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_valid),
        .stat  (stat),
        .cmd   (cmd),
        .idle  (idle)
    );

    skp_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .seed        (seed),
        .base_cfg    (base_reg),
        .count_cfg   (count_reg),
        .folds_cfg   (folds_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .value       (value),
        .group_index (group_index),
        .group_end   (group_end),
        .run_end     (run_end)
    );

endmodule

>>> tb/sv/shuffle_kfold_partition_tb.sv
// Testbench: seeded shuffle and fold grouping checked against a local predictor
`timescale 1ns / 1ps
module shuffle_kfold_partition_tb
    import skp_pkg::*;
();

    // Register index with no register behind it
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic signed [31:0] value;
        logic [6:0]         group_index;
        logic               group_end;
        logic               run_end;
    } fold_value_t;

    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  index;
        logic [31:0] data;
        logic [47:0] seed;
        logic        drain;
    } job_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [47:0]        seed = '0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] value;
    logic [6:0]         group_index;
    logic               group_end;
    logic               run_end;

    shuffle_kfold_partition DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .seed(seed),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_stall(out_stall),
        .value(value), .group_index(group_index),
        .group_end(group_end), .run_end(run_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state and configuration
    logic [31:0]  pred_base = 32'd0;
    logic [6:0]   pred_count = 7'd64;
    logic [6:0]   pred_folds = 7'd4;
    logic [5:0]   perm [64];
    logic [47:0]  lcg;

    fold_value_t  expected_values [$];
    job_t         pending_jobs [$];
    int           errors = 0;
    int           runs_done = 0;
    int           values_seen = 0;
    longint       cycle = 0;
    bit           stim_done = 0;
    bit           quiet = 0;
    int           send_gap = 0;
    int           recv_gap = 0;

    function automatic void apply_reg(input logic [1:0] idx, input logic [31:0] d);
        if (idx == REG_BASE)
            pred_base = d;
        else if (idx == REG_COUNT)
            pred_count = d[6:0];
        else if (idx == REG_FOLDS)
            pred_folds = d[6:0];
    endfunction

    // Shuffle, cut into folds, sort each fold and queue the emitted values
    function automatic void predict_run(input logic [47:0] s);
        int          n;
        int          fc;
        int          bin;
        int          pos;
        int          grp;
        int          len;
        int          j;
        logic [5:0]  t;
        logic [95:0] prod;
        logic [31:0] vals [64];
        logic [31:0] key;
        int          b;
        fold_value_t r;
        n = int'(pred_count);
        fc = int'(pred_folds);
        if (n < 1) n = 1;
        if (n > 64) n = 64;
        if (fc < 1) fc = 1;
        lcg = s;
        for (int k = 0; k < n; k++)
            perm[k] = k[5:0];
        for (int i = n; i >= 2; i--)
        begin
            prod = 96'(lcg) * 96'(LCG_MUL) + 96'(LCG_ADD);
            lcg = prod[47:0];
            prod = 96'(i) * 96'(lcg);
            j = int'(prod >> 48) + 1;
            t = perm[i-1];
            perm[i-1] = perm[j-1];
            perm[j-1] = t;
        end
        bin = n / fc;
        pos = 0;
        grp = 0;
        while (pos < n)
        begin
            len = n - pos;
            if (grp < fc && len > bin + 1)
                len = bin + 1;
            for (int k = 0; k < len; k++)
                vals[k] = pred_base + 32'(perm[pos+k]);
            for (int a = 1; a < len; a++)
            begin
                key = vals[a];
                b = a;
                while (b > 0 && $signed(vals[b-1]) > $signed(key))
                begin
                    vals[b] = vals[b-1];
                    b--;
                end
                vals[b] = key;
            end
            for (int k = 0; k < len; k++)
            begin
                r.value = vals[k];
                r.group_index = grp[6:0];
                r.group_end = (k + 1 == len);
                r.run_end = (pos + k + 1 == n);
                expected_values = {expected_values, r};
            end
            pos += len;
            if (grp < fc)
                grp++;
        end
    endfunction

    function automatic void add_cfg(input logic [1:0] idx, input logic [31:0] d);
        job_t jb;
        jb = '0;
        jb.is_cfg = 1'b1;
        jb.index = idx;
        jb.data = d;
        pending_jobs = {pending_jobs, jb};
    endfunction

    function automatic void add_seed(input logic [47:0] s);
        job_t jb;
        jb = '0;
        jb.seed = s;
        pending_jobs = {pending_jobs, jb};
    endfunction

    function automatic void add_drain();
        job_t jb;
        jb = '0;
        jb.drain = 1'b1;
        pending_jobs = {pending_jobs, jb};
    endfunction

    function automatic logic [47:0] rand_seed();
        logic [63:0] rv;
        rv = {$urandom(), $urandom()};
        return rv[47:0];
    endfunction

    // Driver: one job at a time; register writes only once the block is drained
    int  settle = 0;
    bit  cfg_busy = 0;
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_valid <= 1'b0;
                cfg_busy = 0;
            end
            if (in_valid && !in_stall)
            begin
                predict_run(seed);
                runs_done++;
                in_valid <= 1'b0;
            end
            else if (!in_valid && !cfg_busy && pending_jobs.size() > 0)
            begin
                if (pending_jobs[0].drain || pending_jobs[0].is_cfg)
                begin
                    // hold until every value has come back, then let the block settle
                    if (expected_values.size() != 0 || in_stall)
                        settle = 0;
                    else if (settle < 20)
                        settle++;
                    else if (pending_jobs[0].drain)
                    begin
                        void'(pending_jobs.pop_front());
                        settle = 0;
                    end
                    else
                    begin
                        apply_reg(pending_jobs[0].index, pending_jobs[0].data);
                        cfg_index <= pending_jobs[0].index;
                        cfg_data <= pending_jobs[0].data;
                        cfg_valid <= 1'b1;
                        cfg_busy = 1;
                        void'(pending_jobs.pop_front());
                    end
                end
                else if (send_gap > 0)
                    send_gap--;
                else if (!quiet && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 17);
                else
                begin
                    seed <= pending_jobs[0].seed;
                    in_valid <= 1'b1;
                    void'(pending_jobs.pop_front());
                end
            end
            else if (!in_valid && !cfg_busy && !stim_done)
                stim_done = 1;
        end
    end

    // Monitor: check each transfer and stall in bursts
    always @(posedge clk)
    begin
        fold_value_t got;
        fold_value_t exp_v;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = {value, group_index, group_end, run_end};
                values_seen++;
                if (expected_values.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected value %0d group %0d", value, group_index);
                end
                else
                begin
                    exp_v = expected_values.pop_front();
                    if (got !== exp_v)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                                exp_v.value, exp_v.group_index, exp_v.group_end,
                                exp_v.run_end, value, group_index, group_end, run_end);
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= (recv_gap != 0);
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
            begin
                recv_gap = $urandom_range(1, 17);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        int n_random;
        logic [31:0] bases [5];
        bases[0] = 32'h8000_0000;
        bases[1] = 32'h7FFF_FFC0;
        bases[2] = 32'h7FFF_FFF0;
        bases[3] = 32'hFFFF_FFF8;
        bases[4] = 32'd0;

        // Directed: seed extremes under reset settings
        add_seed(48'h0);
        add_seed(48'hFFFF_FFFF_FFFF);
        add_seed(48'hAAAA_AAAA_AAAA);
        add_seed(48'h5555_5555_5555);
        // count zero, one fold zero, one item
        add_cfg(REG_COUNT, 32'd0);
        add_cfg(REG_FOLDS, 32'd0);
        add_seed(rand_seed());
        add_cfg(REG_COUNT, 32'd1);
        add_seed(rand_seed());
        // saturated count, max folds, unused index, wrap across sign boundary
        add_cfg(REG_COUNT, 32'h7F);
        add_cfg(REG_FOLDS, 32'h7F);
        add_cfg(REG_SPARE, 32'hFFFF_FFFF);
        add_cfg(REG_BASE, 32'h7FFF_FFF0);
        add_seed(rand_seed());
        add_cfg(REG_FOLDS, 32'd64);
        add_seed(rand_seed());
        // single fold with all items, short final fold, empty leftover
        add_cfg(REG_BASE, 32'h8000_0000);
        add_cfg(REG_COUNT, 32'd64);
        add_cfg(REG_FOLDS, 32'd1);
        add_seed(rand_seed());
        add_cfg(REG_COUNT, 32'd10);
        add_cfg(REG_FOLDS, 32'd3);
        add_seed(rand_seed());
        add_cfg(REG_FOLDS, 32'd5);
        add_seed(rand_seed());
        add_cfg(REG_BASE, 32'hFFFF_FFFF);
        add_cfg(REG_FOLDS, 32'd9);
        add_seed(rand_seed());
        add_drain();

        // Random phases: new settings, then a burst of seeds
        n_random = 0;
        while (n_random < 160)
        begin
            if ($urandom_range(0, 3) == 0)
                add_cfg(REG_BASE, bases[$urandom_range(0, 4)]);
            else
                add_cfg(REG_BASE, $urandom());
            if ($urandom_range(0, 7) == 0)
                add_cfg(REG_COUNT, $urandom_range(0, 127));
            else
                add_cfg(REG_COUNT, $urandom_range(1, 24));
            add_cfg(REG_FOLDS, $urandom_range(0, 12) == 0 ? $urandom_range(0, 127)
                                                          : $urandom_range(1, 8));
            if ($urandom_range(0, 5) == 0)
                add_cfg(REG_SPARE, $urandom());
            for (int k = $urandom_range(2, 8); k > 0; k--)
            begin
                add_seed(rand_seed());
                n_random++;
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_jobs.size() < 30);
        quiet = 1;
        wait (stim_done);
        wait (expected_values.size() == 0 && !in_stall);
        repeat (50) @(posedge clk);
        $display("Ran %0d shuffles across settings from 1 to 64 items, %0d values checked.",
            runs_done, values_seen);
        if (errors == 0 && expected_values.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (cycle > 64'd4_000_000)
        begin
            $display("timeout after %0d cycles", cycle);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
